[sv/crlpc_pkg.sv]
// Package for the crash-line pattern classifier.
// Holds the phrase list, the group tables and the shared sizes; used by every module.
package crlpc_pkg;

   localparam int MAX_LINE_DEFAULT = 4096;
   localparam int WINDOW_DEFAULT = 31;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int PHRASE_CHARS = 31;
   localparam int NUM_PHRASES = 39;
   localparam int NUM_GROUPS = 7;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN = 8'h0D;
   localparam logic [7:0] CHAR_OPEN = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [2:0] GROUP_SKIP = 3'd0;
   localparam logic [2:0] GROUP_PANIC = 3'd1;
   localparam logic [2:0] GROUP_OOPS = 3'd2;
   localparam logic [2:0] GROUP_TRACE = 3'd3;
   localparam logic [2:0] GROUP_LOCKUP = 3'd4;
   localparam logic [2:0] GROUP_FS = 3'd5;
   localparam logic [2:0] GROUP_RESOURCE = 3'd6;

   typedef struct packed {
      logic [PHRASE_CHARS*8-1:0] text;
      logic [2:0]                group;
   } phrase_type;

   typedef struct packed {
      logic [1:0] severity;
      logic [2:0] category;
   } class_type;

   localparam phrase_type PHRASES [NUM_PHRASES] = '{
      '{"kernel panic detection skipped", GROUP_SKIP},
      '{"client bug:", GROUP_SKIP},
      '{"kernel panic - not syncing", GROUP_PANIC},
      '{"panic:", GROUP_PANIC},
      '{"fatal exception", GROUP_PANIC},
      '{"oops:", GROUP_OOPS},
      '{"kernel bug", GROUP_OOPS},
      '{"unable to handle kernel", GROUP_OOPS},
      '{"null pointer dereference", GROUP_OOPS},
      '{"general protection fault", GROUP_OOPS},
      '{"call trace:", GROUP_TRACE},
      '{"rip:", GROUP_TRACE},
      '{"eip:", GROUP_TRACE},
      '{"hard lockup", GROUP_LOCKUP},
      '{"soft lockup", GROUP_LOCKUP},
      '{"hung task", GROUP_LOCKUP},
      '{"blocked for more than", GROUP_LOCKUP},
      '{"watchdog: bug", GROUP_LOCKUP},
      '{"watchdog: hard lockup", GROUP_LOCKUP},
      '{"watchdog: soft lockup", GROUP_LOCKUP},
      '{"ext4-fs error", GROUP_FS},
      '{"ext4-fs warning", GROUP_FS},
      '{"xfs error", GROUP_FS},
      '{"xfs corruption", GROUP_FS},
      '{"xfs internal error", GROUP_FS},
      '{"btrfs error", GROUP_FS},
      '{"btrfs warning", GROUP_FS},
      '{"btrfs critical", GROUP_FS},
      '{"jbd2: error", GROUP_FS},
      '{"journal abort", GROUP_FS},
      '{"aborting journal", GROUP_FS},
      '{"remounting filesystem read-only", GROUP_FS},
      '{"metadata corruption", GROUP_FS},
      '{"out of memory", GROUP_RESOURCE},
      '{"oom-killer", GROUP_RESOURCE},
      '{"killed process", GROUP_RESOURCE},
      '{"segfault", GROUP_RESOURCE},
      '{"i/o error", GROUP_RESOURCE},
      '{"buffer i/o error", GROUP_RESOURCE}
   };

   function automatic class_type classify(input logic [NUM_GROUPS-1:0] hits);
      class_type res;
      res = '{severity: 2'd1, category: 3'd5};
      if (hits[GROUP_PANIC]) begin
         res = '{severity: 2'd3, category: 3'd0};
      end else if (hits[GROUP_OOPS]) begin
         res = '{severity: 2'd3, category: 3'd1};
      end else if (hits[GROUP_TRACE]) begin
         res = '{severity: 2'd2, category: 3'd2};
      end else if (hits[GROUP_LOCKUP]) begin
         res = '{severity: 2'd2, category: 3'd3};
      end else if (hits[GROUP_FS]) begin
         res = '{severity: 2'd2, category: 3'd4};
      end
      return res;
   endfunction

endpackage

[sv/crlpc_front.sv]
// Front part: takes bytes, keeps the line window and line state, and classifies each line.
// Depends on crlpc_pkg; pushes one record per reported line into the queue.
module crlpc_front import crlpc_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEFAULT,
   parameter int WINDOW = WINDOW_DEFAULT,
   parameter int PW = $clog2(MAX_LINE + 2)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    byte_value,
   input  logic          end_of_text,
   output logic          push,
   output class_type     push_class,
   output logic [31:0]   push_number,
   output logic [PW-1:0] push_length,
   output logic [PW-1:0] push_stamp
);

   localparam int HIST = WINDOW - 1;
   localparam logic [PW-1:0] LIMIT = PW'(MAX_LINE);
   localparam logic [PW-1:0] SAT = PW'(MAX_LINE + 1);

   logic [7:0] recent_ff [HIST];
   logic [7:0] recent_in [HIST];
   logic [NUM_GROUPS-1:0] hits_ff, hits_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic cr_ff, cr_in;
   logic [PW-1:0] stamp_ff, stamp_in;
   logic [31:0] index_ff, index_in;
   logic open_ff, open_in;

   logic [7:0] folded;
   logic [7:0] win [WINDOW];
   logic [NUM_GROUPS-1:0] match_hits;
   logic in_range;
   logic [NUM_GROUPS-1:0] t_hits, f_hits;
   logic [PW-1:0] t_pos, t_stamp, f_pos, f_stamp;
   logic t_cr, t_open, f_cr;
   logic newline, finish;

   assign newline = (byte_value == CHAR_NEWLINE);
   assign finish = newline || end_of_text;
   assign in_range = (pos_ff < LIMIT);
   assign folded = (byte_value >= CHAR_UPPER_A && byte_value <= CHAR_UPPER_Z) ?
                   byte_value + CASE_OFFSET : byte_value;

   always_comb begin
      win[0] = folded;
      for (int k = 1; k < WINDOW; k++) begin
         win[k] = recent_ff[k-1];
      end
   end

   always_comb begin
      logic ok;
      match_hits = '0;
      for (int i = 0; i < NUM_PHRASES; i++) begin
         ok = 1'b1;
         for (int k = 0; k < PHRASE_CHARS; k++) begin
            if (PHRASES[i].text[8*k +: 8] != 8'h00 && PHRASES[i].text[8*k +: 8] != win[k]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            match_hits[PHRASES[i].group] = 1'b1;
         end
      end
   end

   always_comb begin
      t_hits = hits_ff;
      t_open = open_ff;
      t_stamp = stamp_ff;
      if (in_range) begin
         t_hits = hits_ff | match_hits;
         if (pos_ff == '0 && byte_value == CHAR_OPEN) begin
            t_open = 1'b1;
         end
         if (t_open && stamp_ff == '0 && byte_value == CHAR_CLOSE) begin
            t_stamp = pos_ff + PW'(1);
         end
      end
      t_cr = (byte_value == CHAR_RETURN);
      t_pos = (pos_ff < SAT) ? pos_ff + PW'(1) : SAT;
   end

   assign f_hits = newline ? hits_ff : t_hits;
   assign f_pos = newline ? pos_ff : t_pos;
   assign f_cr = newline ? cr_ff : t_cr;
   assign f_stamp = newline ? stamp_ff : t_stamp;

   assign push = accept && finish && !f_hits[GROUP_SKIP] && (f_hits[NUM_GROUPS-1:1] != '0);
   assign push_class = classify(f_hits);
   assign push_number = index_ff;
   assign push_length = (f_pos > LIMIT) ? LIMIT : f_pos - PW'(f_cr);
   assign push_stamp = f_stamp;

   always_comb begin
      recent_in = recent_ff;
      hits_in = hits_ff;
      pos_in = pos_ff;
      cr_in = cr_ff;
      stamp_in = stamp_ff;
      open_in = open_ff;
      index_in = index_ff;
      if (accept) begin
         if (finish) begin
            for (int i = 0; i < HIST; i++) begin
               recent_in[i] = 8'h00;
            end
            hits_in = '0;
            pos_in = '0;
            cr_in = 1'b0;
            stamp_in = '0;
            open_in = 1'b0;
            index_in = end_of_text ? 32'd0 : index_ff + 32'd1;
         end else begin
            if (in_range) begin
               recent_in[0] = folded;
               for (int i = 1; i < HIST; i++) begin
                  recent_in[i] = recent_ff[i-1];
               end
            end
            hits_in = t_hits;
            pos_in = t_pos;
            cr_in = t_cr;
            stamp_in = t_stamp;
            open_in = t_open;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST; i++) begin
            recent_ff[i] <= 8'h00;
         end
         hits_ff <= '0;
         pos_ff <= '0;
         cr_ff <= 1'b0;
         stamp_ff <= '0;
         open_ff <= 1'b0;
         index_ff <= '0;
      end else begin
         recent_ff <= recent_in;
         hits_ff <= hits_in;
         pos_ff <= pos_in;
         cr_ff <= cr_in;
         stamp_ff <= stamp_in;
         open_ff <= open_in;
         index_ff <= index_in;
      end
   end

   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |=> index_ff == 32'd0)
      else $error("line index did not restart after end of text");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= SAT)
      else $error("line position above saturation");
   a_stamp_bound: assert property (@(posedge clock) disable iff (reset)
      stamp_ff <= LIMIT && (stamp_ff == '0 || open_ff))
      else $error("stamp end without opening bracket");

endmodule

[sv/crlpc_queue.sv]
// Short queue between the front and back parts.
// Depends on crlpc_pkg for its default depth.
module crlpc_queue import crlpc_pkg::*; #(
   parameter int DW = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   input  logic          pop,
   output logic [DW-1:0] pop_data,
   output logic          full,
   output logic          empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DW-1:0] slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("transfer into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("transfer out of an empty queue");

endmodule

[sv/crlpc_back.sv]
// Back part: output register that hands queued records to the result channel.
// Depends on crlpc_pkg for the record fields.
module crlpc_back import crlpc_pkg::*; #(
   parameter int PW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  class_type     head_class,
   input  logic [31:0]   head_number,
   input  logic [PW-1:0] head_length,
   input  logic [PW-1:0] head_stamp,
   output logic          pop,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [1:0]    rsp_severity,
   output logic [2:0]    rsp_category,
   output logic [31:0]   rsp_line_number,
   output logic [PW-1:0] rsp_line_length,
   output logic [PW-1:0] rsp_stamp_length
);

   logic valid_ff, valid_in;
   class_type class_ff;
   logic [31:0] number_ff;
   logic [PW-1:0] length_ff, stamp_ff;

   assign pop = !empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         class_ff <= head_class;
         number_ff <= head_number;
         length_ff <= head_length;
         stamp_ff <= head_stamp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_severity = class_ff.severity;
   assign rsp_category = class_ff.category;
   assign rsp_line_number = number_ff;
   assign rsp_line_length = length_ff;
   assign rsp_stamp_length = stamp_ff;

endmodule

[sv/crash_line_pattern_classifier.sv]
// Crash-line pattern classifier, top level. A line ends on its transfer; its result is
// written into the result queue, then into the output register, and is shown on rsp.
// Throughput: one byte per cycle while req_stall is low; the 39 phrase comparators over the
// byte window work in parallel. req_stall rises only while the four-entry result queue is full.
// Reset is synchronous and clears line state, line index, queue and output valid flag.
module crash_line_pattern_classifier import crlpc_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEFAULT,
   parameter int WINDOW = WINDOW_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int PW = $clog2(MAX_LINE + 2)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_byte_value,
   input  logic          req_end_of_text,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_severity,
   output logic [2:0]    rsp_category,
   output logic [31:0]   rsp_line_number,
   output logic [PW-1:0] rsp_line_length,
   output logic [PW-1:0] rsp_stamp_length
);

   localparam int DW = $bits(class_type) + 32 + 2 * PW;

   logic accept, push, pop, full, empty;
   class_type push_class, head_class;
   logic [31:0] push_number, head_number;
   logic [PW-1:0] push_length, push_stamp, head_length, head_stamp;

   assign req_stall = full;
   assign accept = req_valid && !full;

   crlpc_front #(.MAX_LINE(MAX_LINE), .WINDOW(WINDOW), .PW(PW)) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .byte_value(req_byte_value), .end_of_text(req_end_of_text),
      .push(push), .push_class(push_class), .push_number(push_number),
      .push_length(push_length), .push_stamp(push_stamp)
   );

   crlpc_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push),
      .push_data({push_class, push_number, push_length, push_stamp}),
      .pop(pop), .pop_data({head_class, head_number, head_length, head_stamp}),
      .full(full), .empty(empty)
   );

   crlpc_back #(.PW(PW)) u_back (
      .clock(clock), .reset(reset), .empty(empty),
      .head_class(head_class), .head_number(head_number),
      .head_length(head_length), .head_stamp(head_stamp), .pop(pop),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .rsp_severity(rsp_severity),
      .rsp_category(rsp_category), .rsp_line_number(rsp_line_number),
      .rsp_line_length(rsp_line_length), .rsp_stamp_length(rsp_stamp_length)
   );

endmodule

[dv/crlpc_checker.sv]
`timescale 1ns / 100ps
// Checker for the crash-line pattern classifier: predicts line results from byte transfers.
// Depends on crlpc_pkg for the phrase list and group codes.
module crlpc_checker import crlpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_severity,
   input  logic [2:0]  rsp_category,
   input  logic [31:0] rsp_line_number,
   input  logic [12:0] rsp_line_length,
   input  logic [12:0] rsp_stamp_length,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      logic [1:0]  severity;
      logic [2:0]  category;
      logic [31:0] line_number;
      logic [12:0] line_length;
      logic [12:0] stamp_length;
   } line_result_type;

   line_result_type expected_lines[$];

   logic [7:0]  window_bytes [30];
   logic [6:0]  seen_groups;
   int          line_pos;
   logic        ended_in_return;
   int          stamp_len;
   logic [31:0] line_idx;
   logic        bracket_start;

   function automatic int phrase_chars(int p);
      int n;
      n = 0;
      while (n < PHRASE_CHARS && PHRASES[p].text[8*n +: 8] != 8'h00) n++;
      return n;
   endfunction

   task automatic clear_line_state();
      for (int i = 0; i < 30; i++) window_bytes[i] = 8'h00;
      seen_groups = '0;
      line_pos = 0;
      ended_in_return = 1'b0;
      stamp_len = 0;
      bracket_start = 1'b0;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      logic [7:0] c;
      logic       hit;
      int         n;
      if (line_pos < MAX_LINE_DEFAULT) begin
         c = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
         for (int p = 0; p < NUM_PHRASES; p++) begin
            n = phrase_chars(p);
            hit = (n > 0);
            for (int k = 0; k < n; k++) begin
               if (PHRASES[p].text[8*k +: 8] != ((k == 0) ? c : window_bytes[k-1])) hit = 1'b0;
            end
            if (hit) seen_groups[PHRASES[p].group] = 1'b1;
         end
         if (line_pos == 0 && b == CHAR_OPEN) bracket_start = 1'b1;
         if (bracket_start && stamp_len == 0 && b == CHAR_CLOSE) stamp_len = line_pos + 1;
         for (int i = 29; i > 0; i--) window_bytes[i] = window_bytes[i-1];
         window_bytes[0] = c;
      end
      ended_in_return = (b == CHAR_RETURN);
      line_pos = (line_pos < MAX_LINE_DEFAULT + 1) ? line_pos + 1 : MAX_LINE_DEFAULT + 1;
   endtask

   task automatic close_line();
      line_result_type r;
      int              len;
      if (!seen_groups[GROUP_SKIP] && seen_groups[6:1] != 0) begin
         if (seen_groups[GROUP_PANIC]) begin
            r.severity = 2'd3; r.category = 3'd0;
         end else if (seen_groups[GROUP_OOPS]) begin
            r.severity = 2'd3; r.category = 3'd1;
         end else if (seen_groups[GROUP_TRACE]) begin
            r.severity = 2'd2; r.category = 3'd2;
         end else if (seen_groups[GROUP_LOCKUP]) begin
            r.severity = 2'd2; r.category = 3'd3;
         end else if (seen_groups[GROUP_FS]) begin
            r.severity = 2'd2; r.category = 3'd4;
         end else begin
            r.severity = 2'd1; r.category = 3'd5;
         end
         len = (line_pos > MAX_LINE_DEFAULT) ? MAX_LINE_DEFAULT : line_pos - ended_in_return;
         r.line_number = line_idx;
         r.line_length = len[12:0];
         r.stamp_length = stamp_len[12:0];
         expected_lines = {expected_lines, r};
      end
      line_idx = line_idx + 1;
      clear_line_state();
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         expected_lines.delete();
         clear_line_state();
         line_idx = '0;
         fail_count = 0;
         result_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_byte_value == CHAR_NEWLINE) begin
               close_line();
            end else begin
               absorb_byte(req_byte_value);
               if (req_end_of_text) close_line();
            end
            if (req_end_of_text) line_idx = '0;
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_lines.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result sev=%0d cat=%0d line=%0d len=%0d stamp=%0d",
                        $time, rsp_severity, rsp_category, rsp_line_number,
                        rsp_line_length, rsp_stamp_length);
            end else begin
               want = expected_lines.pop_front();
               if (want.severity !== rsp_severity) begin
                  fail_count++;
                  $display("%0t: severity expected %0d actual %0d", $time, want.severity,
                           rsp_severity);
               end
               if (want.category !== rsp_category) begin
                  fail_count++;
                  $display("%0t: category expected %0d actual %0d", $time, want.category,
                           rsp_category);
               end
               if (want.line_number !== rsp_line_number) begin
                  fail_count++;
                  $display("%0t: line_number expected %0d actual %0d", $time,
                           want.line_number, rsp_line_number);
               end
               if (want.line_length !== rsp_line_length) begin
                  fail_count++;
                  $display("%0t: line_length expected %0d actual %0d", $time,
                           want.line_length, rsp_line_length);
               end
               if (want.stamp_length !== rsp_stamp_length) begin
                  fail_count++;
                  $display("%0t: stamp_length expected %0d actual %0d", $time,
                           want.stamp_length, rsp_stamp_length);
               end
            end
         end
      end
      pending_count = expected_lines.size();
   end

endmodule

[dv/tb_crash_line_pattern_classifier.sv]
`timescale 1ns / 100ps
// Testbench top for the crash-line pattern classifier: clock, reset, byte stimulus and verdict.
// Depends on crlpc_pkg, the classifier RTL and crlpc_checker.
module tb_crash_line_pattern_classifier import crlpc_pkg::*; ();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_severity;
   logic [2:0]  rsp_category;
   logic [31:0] rsp_line_number;
   logic [12:0] rsp_line_length;
   logic [12:0] rsp_stamp_length;
   int          fail_count, pending_count, result_count;
   int          bytes_sent = 0;
   int          lines_sent = 0;
   bit          quiet = 1'b0;
   int          stall_left = 0;
   logic [7:0]  line_bytes[$];

   always #5 clock = ~clock;

   crash_line_pattern_classifier dut (.*);

   crlpc_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 16);
         rsp_stall <= 1'b1;
      end
   end

   task automatic append_byte(input logic [7:0] b);
      line_bytes = {line_bytes, b};
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eot);
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_line_bytes(input logic eot);
      for (int i = 0; i < line_bytes.size(); i++)
         send_byte(line_bytes[i], eot && (i == line_bytes.size() - 1));
      lines_sent++;
      line_bytes.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   task automatic push_phrase(input int p, input int keep, input bit shout);
      int         n;
      logic [7:0] c;
      n = 0;
      while (n < PHRASE_CHARS && PHRASES[p].text[8*n +: 8] != 8'h00) n++;
      if (keep > n) keep = n;
      for (int j = 0; j < keep; j++) begin
         c = PHRASES[p].text[8*(n-1-j) +: 8];
         if (shout && $urandom_range(0, 1) && c >= 8'h61 && c <= 8'h7A) c = c - CASE_OFFSET;
         append_byte(c);
      end
   endtask

   task automatic push_filler(input int n, input bit any_byte);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         c = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
         if (c == CHAR_NEWLINE) c = 8'hFF;
         append_byte(c);
      end
   endtask

   initial begin
      int   kind;
      logic eot;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text("[12.5] Kernel PANIC - not syncing\n"); send_line_bytes(1'b0);
      push_text("CLIENT BUG: oops: null\n"); send_line_bytes(1'b0);
      push_text("\n"); send_line_bytes(1'b0);
      push_text("call trace:\r\n"); send_line_bytes(1'b0);
      push_text("[x watchdog: hard lockup\n"); send_line_bytes(1'b0);
      push_text("EXT4-fs error\n"); send_line_bytes(1'b0);
      push_text("[1] out of memory"); send_line_bytes(1'b1);
      push_text("segfault\n"); send_line_bytes(1'b1);
      append_byte(8'h00); push_text("rip:\n"); send_line_bytes(1'b0);
      push_text("....hung task\r\n"); send_line_bytes(1'b0);
      push_text("[......]eip:\n"); send_line_bytes(1'b0);

      while (bytes_sent < 1350) begin
         if (bytes_sent > 1150) quiet = 1'b1;
         kind = $urandom_range(0, 9);
         if ($urandom_range(0, 2) == 0) begin
            push_text("[");
            push_filler($urandom_range(0, 8), 1'b0);
            push_text("] ");
         end
         push_filler($urandom_range(0, 6), kind == 9);
         if (kind < 7) begin
            push_phrase($urandom_range(0, NUM_PHRASES - 1), PHRASE_CHARS, 1'b1);
            if ($urandom_range(0, 3) == 0)
               push_phrase($urandom_range(0, NUM_PHRASES - 1), PHRASE_CHARS, 1'b1);
         end else if (kind == 7) begin
            push_phrase($urandom_range(0, NUM_PHRASES - 1), $urandom_range(1, 12), 1'b1);
         end else begin
            push_filler($urandom_range(1, 30), kind == 9);
         end
         push_filler($urandom_range(0, 5), kind == 9);
         if ($urandom_range(0, 3) == 0) append_byte(CHAR_RETURN);
         eot = ($urandom_range(0, 9) == 0);
         if (!eot || $urandom_range(0, 1)) append_byte(CHAR_NEWLINE);
         send_line_bytes(eot);
      end
      quiet = 1'b1;
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d lines; %0d classified lines were checked.",
               bytes_sent, lines_sent, result_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
